// ----- hdl/assert_macros.svh -----
// Assertion helpers for the checker file.
// The including module must provide clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/clns_pkg.sv -----
`timescale 1ns / 1ps

package clns_pkg;

  typedef enum logic [2:0] {
    OP_INIT  = 3'd0,
    OP_CMD   = 3'd1,
    OP_DATA  = 3'd2,
    OP_GOTO  = 3'd3,
    OP_CLEAR = 3'd4,
    OP_HOME  = 3'd5
  } op_e;

  // Extra hold added to a byte's second strobe
  typedef enum logic [1:0] {
    EXTRA_NONE = 2'd0,
    EXTRA_5MS  = 2'd1,
    EXTRA_1MS  = 2'd2,
    EXTRA_2MS  = 2'd3
  } extra_e;

  // One queued request, already decoded
  typedef struct packed {
    logic       is_init;
    logic       rs;
    logic [7:0] data;
    extra_e     extra;
  } job_t;

  localparam int unsigned WaitW     = 15;
  localparam int unsigned ExtraW    = 13;
  localparam int unsigned GapW      = 10;
  localparam int unsigned StepW     = 5;
  localparam int unsigned InitSteps = 19;

  localparam logic [GapW-1:0]  GapResetUs = 10'd150;
  localparam logic [WaitW-1:0] InitIdleUs = 15'd20000;

  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_HOME     = 8'h02;
  localparam logic [7:0] CMD_SET_ADDR = 8'h80;
  localparam logic [7:0] CMD_WAKE     = 8'h03;
  localparam logic [7:0] CMD_4BIT     = 8'h02;
  localparam logic [7:0] CMD_FUNC     = 8'h28;
  localparam logic [7:0] CMD_DISP_OFF = 8'h08;
  localparam logic [7:0] CMD_ENTRY    = 8'h06;
  localparam logic [7:0] CMD_DISP_ON  = 8'h0f;

  function automatic logic [ExtraW-1:0] extra_us(extra_e e);
    logic [ExtraW-1:0] r;
    case (e)
      EXTRA_5MS: r = 13'd5000;
      EXTRA_1MS: r = 13'd1000;
      EXTRA_2MS: r = 13'd2000;
      default:   r = '0;
    endcase
    return r;
  endfunction

  // Power-up sequence, one entry per byte
  function automatic logic [7:0] init_byte(logic [3:0] idx);
    logic [7:0] r;
    case (idx)
      4'd0, 4'd1, 4'd2: r = CMD_WAKE;
      4'd3:             r = CMD_4BIT;
      4'd4:             r = CMD_FUNC;
      4'd5:             r = CMD_DISP_OFF;
      4'd6:             r = CMD_CLEAR;
      4'd7:             r = CMD_ENTRY;
      default:          r = CMD_DISP_ON;
    endcase
    return r;
  endfunction

  function automatic extra_e init_extra(logic [3:0] idx);
    extra_e r;
    case (idx)
      4'd0:       r = EXTRA_5MS;
      4'd1, 4'd2: r = EXTRA_1MS;
      4'd6:       r = EXTRA_2MS;
      default:    r = EXTRA_NONE;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/clns_front.sv -----
`timescale 1ns / 1ps

module clns_front (
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [2:0]      op_i,
  input  logic [7:0]      value_i,
  input  logic [5:0]      col_i,
  input  logic            row_i,
  input  logic            q_full_i,
  output logic            push_o,
  output clns_pkg::job_t  push_job_o
);
  import clns_pkg::*;

  logic       known;
  logic [7:0] addr;

  assign in_ready_o = !q_full_i;
  // DDRAM address: row 1 starts at 0x40
  assign addr = {2'b00, col_i} + {1'b0, row_i, 6'b000000};

  always_comb begin
    known      = 1'b1;
    push_job_o = '{is_init: 1'b0, rs: 1'b0, data: value_i, extra: EXTRA_NONE};
    case (op_e'(op_i))
      OP_INIT: begin
        push_job_o.is_init = 1'b1;
      end
      OP_CMD: begin
      end
      OP_DATA: begin
        push_job_o.rs = 1'b1;
      end
      OP_GOTO: begin
        push_job_o.data = CMD_SET_ADDR | addr;
      end
      OP_CLEAR: begin
        push_job_o.data  = CMD_CLEAR;
        push_job_o.extra = EXTRA_2MS;
      end
      OP_HOME: begin
        push_job_o.data  = CMD_HOME;
        push_job_o.extra = EXTRA_2MS;
      end
      default: begin
        known = 1'b0;  // unused op codes are consumed and dropped
      end
    endcase
  end

  assign push_o = in_valid_i && !q_full_i && known;

endmodule

// ----- hdl/clns_queue.sv -----
`timescale 1ns / 1ps

module clns_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  clns_pkg::job_t push_job_i,
  input  logic           pop_i,
  output clns_pkg::job_t head_o,
  output logic           empty_o,
  output logic           full_o
);
  import clns_pkg::*;

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);

  job_t            mem_q [Depth];
  logic [IdxW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LastIdx) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == LastIdx) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

endmodule

// ----- hdl/clns_back.sv -----
`timescale 1ns / 1ps

module clns_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [clns_pkg::GapW-1:0]   gap_us_i,
  input  clns_pkg::job_t              head_i,
  input  logic                        empty_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        reg_select_o,
  output logic                        strobe_res_o,
  output logic [3:0]                  nibble_o,
  output logic [clns_pkg::WaitW-1:0]  wait_us_o,
  output logic                        last_o
);
  import clns_pkg::*;

  logic [StepW-1:0] step_q, step_d, step_m1;
  logic             vld_q, vld_d;
  logic             rs_q, stb_q, last_q;
  logic [3:0]       nib_q;
  logic [WaitW-1:0] wait_q;

  logic             load, gen;
  logic             ev_stb, ev_last, ev_low;
  logic [7:0]       ev_byte;
  extra_e           ev_extra;
  logic [3:0]       ev_nib;
  logic [WaitW-1:0] ev_wait;

  assign load    = !vld_q || out_ready_i;
  assign gen     = load && !empty_i;
  assign step_m1 = step_q - 1'b1;

  always_comb begin
    if (head_i.is_init) begin
      ev_stb   = (step_q != '0);
      ev_byte  = init_byte(step_m1[4:1]);
      ev_extra = init_extra(step_m1[4:1]);
      ev_low   = step_m1[0];
      ev_last  = (step_q == StepW'(InitSteps - 1));
    end else begin
      ev_stb   = 1'b1;
      ev_byte  = head_i.data;
      ev_extra = head_i.extra;
      ev_low   = step_q[0];
      ev_last  = step_q[0];
    end
    ev_nib = ev_low ? ev_byte[3:0] : ev_byte[7:4];
    if (!ev_stb) begin
      ev_nib  = '0;
      ev_wait = InitIdleUs;
    end else if (ev_low) begin
      ev_wait = WaitW'(gap_us_i) + WaitW'(extra_us(ev_extra));
    end else begin
      ev_wait = '0;
    end
  end

  assign pop_o = gen && ev_last;

  always_comb begin
    step_d = step_q;
    vld_d  = vld_q;
    if (gen) begin
      vld_d  = 1'b1;
      step_d = ev_last ? '0 : step_q + 1'b1;
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      vld_q  <= 1'b0;
    end else begin
      step_q <= step_d;
      vld_q  <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (gen) begin
      rs_q   <= head_i.rs;
      stb_q  <= ev_stb;
      nib_q  <= ev_nib;
      wait_q <= ev_wait;
      last_q <= ev_last;
    end
  end

  assign out_valid_o  = vld_q;
  assign reg_select_o = rs_q;
  assign strobe_res_o = stb_q;
  assign nibble_o     = nib_q;
  assign wait_us_o    = wait_q;
  assign last_o       = last_q;

endmodule

// ----- hdl/char_lcd_nibble_sequencer.sv -----
`timescale 1ns / 1ps
// Character LCD sequencer for a 4-bit HD44780-style bus.
// Slave stream: one beat is one request. tuser carries the op code
// (init, command, data, goto, clear, home); tdata carries value, col, row.
// Op codes 6 and 7 are taken and dropped without output.
// Master stream: one beat per pin event. tuser says register select and
// whether enable is pulsed; tdata gives the nibble and the hold time in us;
// tlast marks the final event of a request.
// Init gives 19 beats, every other request 2 beats (high nibble first).
// The first event of a request goes through the request queue and then the
// output register of the back end, once that is free. Events leave at one per
// cycle while the receiver is ready; the event step counter in the back end
// walks the events of each request.
// A 2-entry request queue sits between decode and the sequencer, so new
// requests are taken while earlier ones still play out. When the receiver
// stalls, the output register holds its beat and the queue fills; tready
// drops once the queue is full.
// Reset clears the queue and the output register; byte gap returns to 150 us.
// cfg_we_i writes the byte gap (us) from cfg_wdata_i; write only when idle.

module char_lcd_nibble_sequencer #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: byte gap in microseconds
  input  logic        cfg_we_i,
  input  logic [9:0]  cfg_wdata_i,
  // Requests
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [7:0] value, [13:8] col, [14] row, [15] zero
  input  logic [2:0]  s_axis_tuser,  // [2:0] op
  // Pin events
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [3:0] nibble, [18:4] wait_us, [23:19] zero
  output logic [1:0]  m_axis_tuser,  // [0] reg_select, [1] strobe_res
  output logic        m_axis_tlast
);
  import clns_pkg::*;

  logic [GapW-1:0]  gap_q;
  logic             q_full, q_empty, push, pop;
  job_t             push_job, head;
  logic             rs, stb;
  logic [3:0]       nib;
  logic [WaitW-1:0] wait_us;

  // Byte gap register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= GapResetUs;
    end else if (cfg_we_i) begin
      gap_q <= cfg_wdata_i;
    end
  end

  // Decode: op code to a queued job
  clns_front u_front (
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .op_i       (s_axis_tuser),
    .value_i    (s_axis_tdata[7:0]),
    .col_i      (s_axis_tdata[13:8]),
    .row_i      (s_axis_tdata[14]),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_job_o (push_job)
  );

  clns_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  // Sequencer: plays the head job out as events, pops on its last event
  clns_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .gap_us_i     (gap_q),
    .head_i       (head),
    .empty_i      (q_empty),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .reg_select_o (rs),
    .strobe_res_o (stb),
    .nibble_o     (nib),
    .wait_us_o    (wait_us),
    .last_o       (m_axis_tlast)
  );

  assign m_axis_tuser = {stb, rs};
  assign m_axis_tdata = {5'b00000, wait_us, nib};

endmodule

// ----- hdl/clns_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module clns_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  logic        vld, rdy, stb, rs, fin;
  logic [3:0]  nib;
  logic [14:0] hold_us;
  logic        idle_ok, wake_ok;

  assign vld     = m_axis_tvalid;
  assign rdy     = m_axis_tready;
  assign rs      = m_axis_tuser[0];
  assign stb     = m_axis_tuser[1];
  assign fin     = m_axis_tlast;
  assign nib     = m_axis_tdata[3:0];
  assign hold_us = m_axis_tdata[18:4];
  assign idle_ok = (hold_us == 15'd20000) && !fin && !rs && (nib == 4'd0);
  assign wake_ok = stb && (nib == 4'd0);

  // A request always ends on a strobe, never on the idle wait
  `ASSERT_IMPL(a_last_is_strobe, vld && fin, stb, "last event without strobe")

  // The idle wait is the init lead-in: 20 ms, command side, blank nibble
  `ASSERT_IMPL(a_idle_shape, vld && !stb, idle_ok, "bad idle event")

  // Idle wait taken: next beat is the first high nibble of init
  `ASSERT_NEXT(a_idle_then_wake, vld && rdy && !stb, !vld || wake_ok, "init does not resume")

  // A stalled beat stays up
  `ASSERT_NEXT(a_hold_valid, vld && !rdy, vld && $stable(m_axis_tdata), "stalled beat lost")

endmodule

bind char_lcd_nibble_sequencer clns_checker u_clns_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
